// ----- design/rwpe_pkg.sv -----
// Shared types and constants for the RIFF/WAVE PCM extractor.
`timescale 1ns / 1ps

package rwpe_pkg;

	// Header and chunk tags as they arrive on the byte stream, first byte in the low lane.
	localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
	localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [15:0] FMT_PCM      = 16'd1;
	localparam logic [15:0] PCM_BITS     = 16'd16;
	localparam logic [15:0] MAX_CHANNELS = 16'd8;

	localparam logic [3:0] HDR_LAST_POS  = 4'd11;
	localparam logic [2:0] CHDR_LAST_POS = 3'd7;
	localparam logic [3:0] FMT_BITS_LO   = 4'd14;
	localparam logic [3:0] FMT_LAST_POS  = 4'd15;

	// Result queue geometry.
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_LEVEL_W  = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_HEADER   = 3'd0,
		PH_CHUNK_HDR = 3'd1,
		PH_BODY     = 3'd2,
		PH_PAD      = 3'd3,
		PH_DATA     = 3'd4,
		PH_DONE     = 3'd5,
		PH_FAIL     = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_HDR_BAD = 2'd1,
		ST_NO_PCM = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] wave_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic        is_summary;
		logic [7:0]  pcm_byte;
		logic [31:0] sample_rate_hz;
		logic [3:0]  channel_count;
		logic [31:0] data_byte_count;
		status_t     status;
		logic        last_result;
	} out_item_t;

	// Results of one accepted byte: an optional data byte, then an optional summary.
	typedef struct packed {
		logic      data_vld;
		out_item_t data_res;
		logic      sum_vld;
		out_item_t sum_res;
	} step_res_t;

	typedef struct packed {
		logic [Q_LEVEL_W-1:0] level;
		logic                 room;
	} q_stat_t;

endpackage

// ----- design/rwpe_parser.sv -----
// Byte-wise RIFF/WAVE parse state and the results each byte produces.
`timescale 1ns / 1ps

module rwpe_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  rwpe_pkg::in_item_t item,
	output rwpe_pkg::step_res_t res
);
	import rwpe_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] rem_q, rem_d;
	logic        pad_q, pad_d;
	logic [63:0] shadow_q, shadow_d;
	logic [7:0]  bits_lo_q, bits_lo_d;
	logic [15:0] format_q, format_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] bits_q, bits_d;
	logic [31:0] data_cnt_q, data_cnt_d;
	status_t     err_q, err_d;

	logic [7:0]  b;
	logic [2:0]  hpos;
	logic [31:0] tag_v, rem_v;
	logic        bad;
	logic        fmt_ok;
	status_t     st;

	assign b = item.wave_byte;
	assign hpos = cnt_q[2:0];
	assign fmt_ok = (format_q == FMT_PCM) && (bits_q == PCM_BITS) && (chan_q != 16'd0) &&
		(chan_q <= MAX_CHANNELS) && (rate_q != 32'd0);

	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		tag_d      = tag_q;
		rem_d      = rem_q;
		pad_d      = pad_q;
		shadow_d   = shadow_q;
		bits_lo_d  = bits_lo_q;
		format_d   = format_q;
		chan_d     = chan_q;
		rate_d     = rate_q;
		bits_d     = bits_q;
		data_cnt_d = data_cnt_q;
		err_d      = err_q;
		bad        = 1'b0;
		tag_v      = tag_q;
		rem_v      = rem_q;
		res        = '0;

		case (phase_q)
			PH_HEADER: begin
				if (cnt_q < 4'd4) begin
					bad = (b != RIFF_TAG[8*cnt_q[1:0] +: 8]);
				end else if (cnt_q >= 4'd8 && cnt_q < 4'd12) begin
					bad = (b != WAVE_TAG[8*cnt_q[1:0] +: 8]);
				end
				if (bad) begin
					phase_d = PH_FAIL;
					err_d   = ST_HDR_BAD;
				end else if (cnt_q >= HDR_LAST_POS) begin
					phase_d = PH_CHUNK_HDR;
					cnt_d   = 4'd0;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			PH_CHUNK_HDR: begin
				if (hpos == 3'd0) begin
					tag_v = '0;
					rem_v = '0;
				end
				if (!hpos[2]) begin
					tag_v[8*hpos[1:0] +: 8] = b;
				end else begin
					rem_v[8*hpos[1:0] +: 8] = b;
				end
				tag_d = tag_v;
				rem_d = rem_v;
				if (hpos != CHDR_LAST_POS) begin
					cnt_d = {1'b0, hpos + 3'd1};
				end else begin
					cnt_d = 4'd0;
					pad_d = rem_v[0];
					if (tag_v == TAG_DATA) begin
						if (!fmt_ok) begin
							phase_d = PH_FAIL;
							err_d   = ST_NO_PCM;
						end else begin
							phase_d = (rem_v != 32'd0) ? PH_DATA : PH_DONE;
						end
					end else begin
						shadow_d = '0;
						if (rem_v != 32'd0) begin
							phase_d = PH_BODY;
						end else begin
							phase_d = rem_v[0] ? PH_PAD : PH_CHUNK_HDR;
						end
					end
				end
			end
			PH_BODY: begin
				if (tag_q == TAG_FMT) begin
					if (cnt_q < 4'd8) begin
						shadow_d[8*cnt_q[2:0] +: 8] = b;
					end else if (cnt_q == FMT_BITS_LO) begin
						bits_lo_d = b;
					end
					if (cnt_q == FMT_LAST_POS) begin
						// The fmt body is complete; later bytes of this chunk are skipped.
						format_d = shadow_q[15:0];
						chan_d   = shadow_q[31:16];
						rate_d   = shadow_q[63:32];
						bits_d   = {b, bits_lo_q};
						tag_d    = '0;
					end else begin
						cnt_d = cnt_q + 4'd1;
					end
				end
				rem_d = rem_q - 32'd1;
				if (rem_d == 32'd0) begin
					phase_d = pad_q ? PH_PAD : PH_CHUNK_HDR;
					cnt_d   = 4'd0;
				end
			end
			PH_PAD: begin
				phase_d = PH_CHUNK_HDR;
				cnt_d   = 4'd0;
			end
			PH_DATA: begin
				res.data_vld          = take;
				res.data_res.pcm_byte = b;
				res.data_res.status   = ST_OK;
				data_cnt_d = data_cnt_q + 32'd1;
				rem_d      = rem_q - 32'd1;
				if (rem_d == 32'd0) begin
					phase_d = PH_DONE;
				end
			end
			default: begin
			end
		endcase

		// The summary sees the state as this byte leaves it.
		if (phase_d == PH_HEADER) begin
			st = ST_HDR_BAD;
		end else if (phase_d == PH_FAIL) begin
			st = (err_d == ST_HDR_BAD) ? ST_HDR_BAD : ST_NO_PCM;
		end else if ((phase_d == PH_DATA || phase_d == PH_DONE) && data_cnt_d != 32'd0) begin
			st = ST_OK;
		end else begin
			st = ST_NO_PCM;
		end
		res.sum_vld                  = take && item.end_of_stream;
		res.sum_res.is_summary       = 1'b1;
		res.sum_res.sample_rate_hz   = (st == ST_OK) ? rate_d : 32'd0;
		res.sum_res.channel_count    = (st == ST_OK) ? chan_d[3:0] : 4'd0;
		res.sum_res.data_byte_count  = data_cnt_d;
		res.sum_res.status           = st;
		res.sum_res.last_result      = 1'b1;

		// The final byte of a file returns everything to the reset state.
		if (item.end_of_stream) begin
			phase_d    = PH_HEADER;
			cnt_d      = '0;
			tag_d      = '0;
			rem_d      = '0;
			pad_d      = 1'b0;
			shadow_d   = '0;
			bits_lo_d  = '0;
			format_d   = '0;
			chan_d     = '0;
			rate_d     = '0;
			bits_d     = '0;
			data_cnt_d = '0;
			err_d      = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			cnt_q      <= '0;
			tag_q      <= '0;
			rem_q      <= '0;
			pad_q      <= 1'b0;
			shadow_q   <= '0;
			bits_lo_q  <= '0;
			format_q   <= '0;
			chan_q     <= '0;
			rate_q     <= '0;
			bits_q     <= '0;
			data_cnt_q <= '0;
			err_q      <= ST_OK;
		end else if (take) begin
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
			tag_q      <= tag_d;
			rem_q      <= rem_d;
			pad_q      <= pad_d;
			shadow_q   <= shadow_d;
			bits_lo_q  <= bits_lo_d;
			format_q   <= format_d;
			chan_q     <= chan_d;
			rate_q     <= rate_d;
			bits_q     <= bits_d;
			data_cnt_q <= data_cnt_d;
			err_q      <= err_d;
		end
	end

endmodule

// ----- design/rwpe_out_queue.sv -----
// Small result queue that takes up to two results per cycle and hands out one.
`timescale 1ns / 1ps

module rwpe_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  rwpe_pkg::step_res_t res,
	input  logic                pop,
	output logic                valid,
	output rwpe_pkg::out_item_t head,
	output rwpe_pkg::q_stat_t   stat
);
	import rwpe_pkg::*;

	out_item_t            slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_q, rd_q;
	logic [Q_LEVEL_W-1:0] level_q;
	logic [Q_PTR_W-1:0]   wr_b;
	logic [Q_LEVEL_W-1:0] push_n;
	logic                 do_pop;

	assign valid  = (level_q != '0);
	assign head   = slot_q[rd_q];
	assign do_pop = pop && valid;
	assign wr_b   = wr_q + Q_PTR_W'(res.data_vld);
	assign push_n = Q_LEVEL_W'(res.data_vld) + Q_LEVEL_W'(res.sum_vld);

	// Room for two results keeps a byte that ends the file from overflowing.
	assign stat.level = level_q;
	assign stat.room  = (level_q <= Q_LEVEL_W'(Q_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + Q_PTR_W'(push_n);
			rd_q    <= rd_q + Q_PTR_W'(do_pop);
			level_q <= level_q + push_n - Q_LEVEL_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res.data_vld) begin
			slot_q[wr_q] <= res.data_res;
		end
		if (res.sum_vld) begin
			slot_q[wr_b] <= res.sum_res;
		end
	end

endmodule

// ----- design/riff_wave_pcm_extractor_top.sv -----
// Top level of the RIFF/WAVE PCM extractor: parser plus result queue.
`timescale 1ns / 1ps

// The block takes a WAV file one byte per item and accepts one item every clock
// cycle while byte_stall is low. It checks the twelve-byte RIFF/WAVE header, walks
// the little-endian chunks (skipping the pad byte after an odd-sized chunk), keeps
// the format, channel count, sample rate and sample width from the most recent fmt
// chunk whose body reaches 16 bytes, and at the data chunk header checks for 16-bit
// PCM with one to eight channels and a nonzero rate. Each data byte up to the
// declared size then comes out as a result item with is_summary low; anything after
// the data chunk is ignored. The byte flagged end_of_stream additionally produces a
// summary item (rate, channels, bytes passed, status) and returns the block to its
// reset state, so the next byte starts a new file. A byte is parsed in the cycle it
// is accepted and its results are registered into a four-entry result queue, from
// which they leave in order as the results ahead of them are taken. The queue, not
// the parser, sets the input rate: byte_stall rises while fewer than two queue
// entries are free, so a downstream that takes one result per cycle sees one byte
// per cycle; a final byte yielding a data byte and a summary queues both at once.

module riff_wave_pcm_extractor_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  rwpe_pkg::in_item_t  byte_item,
	output logic                result_valid,
	input  logic                result_stall,
	output rwpe_pkg::out_item_t result_item
);
	import rwpe_pkg::*;

	logic      take;
	step_res_t res;
	q_stat_t   q_stat;

	// A byte is taken only when the queue can absorb both results it may cause.
	assign byte_stall = !q_stat.room;
	assign take       = byte_valid && !byte_stall;

	rwpe_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (byte_item),
		.res    (res)
	);

	rwpe_out_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.pop    (!result_stall),
		.valid  (result_valid),
		.head   (result_item),
		.stat   (q_stat)
	);

	// The queue never holds more entries than it has.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.level <= Q_LEVEL_W'(Q_DEPTH))
		else $error("result queue level exceeds its depth");

	// Results only come from a byte that was actually taken.
	a_res_needs_take: assert property (@(posedge clk) disable iff (!arst_n)
		(res.data_vld || res.sum_vld) |-> take)
		else $error("result produced without an accepted byte");

	// The final byte of a file always leaves a result waiting in the next cycle.
	a_summary_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(take && byte_item.end_of_stream) |=> result_valid)
		else $error("summary missing after final byte");

	// A summary is always the last result of its file and never carries PCM data.
	a_summary_form: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_item.is_summary) |->
			(result_item.last_result && result_item.pcm_byte == 8'd0))
		else $error("malformed summary result");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the RIFF/WAVE PCM extractor top level.
`timescale 1ns / 1ps

// The run streams at least 775 bytes into the block. It opens with a few hand-made
// files: one cut off inside the header, one with a bad header byte, and one whose
// data chunk comes before any fmt chunk. After that come random files. Most are
// well-formed RIFF/WAVE files with random content: junk chunks with odd sizes and
// pad bytes, short and long fmt chunks (some with a bad field, some overridden by a
// later fmt chunk), data chunks of random length, trailing bytes, and random
// truncation. The rest are noise and files with a broken header. A predictor built
// into this module parses every accepted byte and queues the result items that byte
// should produce. The monitor compares each accepted result item, field by field,
// with the oldest queued one.
module testbench;
	import rwpe_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_item_t  byte_item = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result_item;

	riff_wave_pcm_extractor_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Bytes waiting to be offered, and the result items the predictor expects.
	in_item_t   wave_stream[$];
	out_item_t  awaited_results[$];
	logic [7:0] file_bytes[$];

	int mismatches = 0;
	int bytes_taken = 0;
	int results_seen = 0;
	int files_parsed = 0;
	int pcm_bytes_predicted = 0;
	int input_stall_cycles = 0;
	int status_tally[3] = '{0, 0, 0};

	// Parser state of the predictor.
	phase_t      parse_phase;
	logic [3:0]  parse_pos;
	logic [31:0] chunk_id;
	logic [31:0] chunk_left;
	logic        pad_due;
	logic [63:0] fmt_head;
	logic [7:0]  bits_lo_byte;
	logic [15:0] fmt_code;
	logic [15:0] chan_word;
	logic [31:0] rate_word;
	logic [15:0] bits_word;
	logic [31:0] pcm_count;
	status_t     fail_code;

	task automatic clear_parser();
		parse_phase = PH_HEADER;
		parse_pos = '0;
		chunk_id = '0;
		chunk_left = '0;
		pad_due = 1'b0;
		fmt_head = '0;
		bits_lo_byte = '0;
		fmt_code = '0;
		chan_word = '0;
		rate_word = '0;
		bits_word = '0;
		pcm_count = '0;
		fail_code = ST_OK;
	endtask

	// At the end of a chunk body, skip the pad byte if the size was odd.
	task automatic close_chunk_body();
		parse_phase = pad_due ? PH_PAD : PH_CHUNK_HDR;
		parse_pos = '0;
	endtask

	// Parses one accepted byte and queues the result items it causes.
	task automatic parse_wave_byte(in_item_t it);
		logic [7:0] b;
		logic       bad;
		out_item_t  res;
		status_t    verdict;
		b = it.wave_byte;
		case (parse_phase)
			PH_HEADER: begin
				bad = 1'b0;
				if (parse_pos < 4)
					bad = (b != RIFF_TAG[8*parse_pos +: 8]);
				else if (parse_pos >= 8)
					bad = (b != WAVE_TAG[8*(parse_pos-8) +: 8]);
				if (bad) begin
					parse_phase = PH_FAIL;
					fail_code = ST_HDR_BAD;
				end else if (parse_pos >= HDR_LAST_POS) begin
					parse_phase = PH_CHUNK_HDR;
					parse_pos = '0;
				end else begin
					parse_pos = parse_pos + 1'b1;
				end
			end
			PH_CHUNK_HDR: begin
				if (parse_pos[2:0] == 3'd0) begin
					chunk_id = '0;
					chunk_left = '0;
				end
				if (parse_pos[2:0] < 3'd4)
					chunk_id[8*parse_pos[1:0] +: 8] = b;
				else
					chunk_left[8*parse_pos[1:0] +: 8] = b;
				if (parse_pos[2:0] != CHDR_LAST_POS) begin
					parse_pos = parse_pos + 1'b1;
				end else begin
					parse_pos = '0;
					pad_due = chunk_left[0];
					if (chunk_id == TAG_DATA) begin
						if (fmt_code == FMT_PCM && bits_word == PCM_BITS && chan_word != 0 &&
						    chan_word <= MAX_CHANNELS && rate_word != 0) begin
							parse_phase = (chunk_left != 0) ? PH_DATA : PH_DONE;
						end else begin
							parse_phase = PH_FAIL;
							fail_code = ST_NO_PCM;
						end
					end else begin
						fmt_head = '0;
						if (chunk_left != 0)
							parse_phase = PH_BODY;
						else
							close_chunk_body();
					end
				end
			end
			PH_BODY: begin
				// Only a fmt chunk is read; its fields load once 16 body bytes are in.
				if (chunk_id == TAG_FMT) begin
					if (parse_pos < 8)
						fmt_head[8*parse_pos[2:0] +: 8] = b;
					else if (parse_pos == FMT_BITS_LO)
						bits_lo_byte = b;
					if (parse_pos == FMT_LAST_POS) begin
						fmt_code = fmt_head[15:0];
						chan_word = fmt_head[31:16];
						rate_word = fmt_head[63:32];
						bits_word = {b, bits_lo_byte};
						chunk_id = '0;
					end else begin
						parse_pos = parse_pos + 1'b1;
					end
				end
				chunk_left = chunk_left - 1;
				if (chunk_left == 0)
					close_chunk_body();
			end
			PH_PAD: begin
				parse_phase = PH_CHUNK_HDR;
				parse_pos = '0;
			end
			PH_DATA: begin
				res = '0;
				res.pcm_byte = b;
				awaited_results.push_back(res);
				pcm_bytes_predicted++;
				pcm_count = pcm_count + 1;
				chunk_left = chunk_left - 1;
				if (chunk_left == 0)
					parse_phase = PH_DONE;
			end
			default: begin
			end
		endcase

		if (it.end_of_stream) begin
			if (parse_phase == PH_HEADER)
				verdict = ST_HDR_BAD;
			else if (parse_phase == PH_FAIL)
				verdict = (fail_code == ST_HDR_BAD) ? ST_HDR_BAD : ST_NO_PCM;
			else if ((parse_phase == PH_DATA || parse_phase == PH_DONE) && pcm_count != 0)
				verdict = ST_OK;
			else
				verdict = ST_NO_PCM;
			res = '0;
			res.is_summary = 1'b1;
			if (verdict == ST_OK) begin
				res.sample_rate_hz = rate_word;
				res.channel_count = chan_word[3:0];
			end
			res.data_byte_count = pcm_count;
			res.status = verdict;
			res.last_result = 1'b1;
			awaited_results.push_back(res);
			status_tally[verdict]++;
			files_parsed++;
			// The block starts over with the next byte.
			clear_parser();
		end
	endtask

	// One line per mismatch. Printing stops after a while so that a badly broken
	// block cannot flood the log, but every mismatch is still counted.
	task automatic report_mismatch(string what);
		if (mismatches < 40)
			$display("error at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic cmp_field(string field, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
				results_seen, field, got, want));
	endtask

	task automatic check_result(out_item_t got);
		out_item_t want;
		if (awaited_results.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with none expected (summary %0b)",
				results_seen, got.is_summary));
			return;
		end
		want = awaited_results.pop_front();
		cmp_field("is_summary", 32'(got.is_summary), 32'(want.is_summary));
		cmp_field("pcm_byte", 32'(got.pcm_byte), 32'(want.pcm_byte));
		cmp_field("sample_rate_hz", got.sample_rate_hz, want.sample_rate_hz);
		cmp_field("channel_count", 32'(got.channel_count), 32'(want.channel_count));
		cmp_field("data_byte_count", got.data_byte_count, want.data_byte_count);
		cmp_field("status", 32'(got.status), 32'(want.status));
		cmp_field("last_result", 32'(got.last_result), 32'(want.last_result));
	endtask

	// File building: bytes collect in file_bytes, then go to the stream with
	// end_of_stream on the chosen final byte; anything after it is dropped.
	task automatic add_word(logic [31:0] w, int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back(w[8*i +: 8]);
	endtask

	task automatic flush_file(int last_idx);
		for (int i = 0; i <= last_idx; i++)
			wave_stream.push_back('{wave_byte: file_bytes[i], end_of_stream: (i == last_idx)});
		file_bytes.delete();
	endtask

	task automatic add_junk_chunk();
		int len;
		len = $urandom_range(0, 9);
		add_word($urandom, 4);
		add_word(len, 4);
		repeat (len) file_bytes.push_back(8'($urandom));
		if (len % 2 == 1)
			file_bytes.push_back(8'($urandom));
	endtask

	// A fmt chunk of random length; spoil changes one of the format fields, usually to a bad value.
	task automatic add_fmt_chunk(bit spoil);
		int          len;
		int          pick;
		logic [7:0]  body[$];
		logic [15:0] code;
		logic [15:0] chans;
		logic [15:0] width;
		logic [31:0] rate;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			len = $urandom_range(0, 15);
		else if (pick < 7)
			len = 16;
		else
			len = $urandom_range(17, 22);
		code = FMT_PCM;
		chans = 16'($urandom_range(1, 8));
		width = PCM_BITS;
		case ($urandom_range(0, 4))
			0: rate = 32'd8000;
			1: rate = 32'd44100;
			2: rate = 32'hFFFF_FFFF;
			default: rate = $urandom_range(1, 32'hFFFF_FFFF);
		endcase
		if (spoil) begin
			case ($urandom_range(0, 4))
				0: code = 16'($urandom);
				1: width = 16'($urandom_range(0, 40));
				2: chans = 16'd0;
				3: chans = 16'($urandom_range(9, 16'hFFFF));
				default: rate = 32'd0;
			endcase
		end
		for (int i = 0; i < 2; i++) body.push_back(code[8*i +: 8]);
		for (int i = 0; i < 2; i++) body.push_back(chans[8*i +: 8]);
		for (int i = 0; i < 4; i++) body.push_back(rate[8*i +: 8]);
		repeat (6) body.push_back(8'($urandom));
		for (int i = 0; i < 2; i++) body.push_back(width[8*i +: 8]);
		add_word(TAG_FMT, 4);
		add_word(len, 4);
		for (int i = 0; i < len; i++)
			file_bytes.push_back((i < 16) ? body[i] : 8'($urandom));
		if (len % 2 == 1)
			file_bytes.push_back(8'($urandom));
	endtask

	task automatic build_wave_file();
		int          kind;
		int          pick;
		int          n_fmt;
		int          n_data;
		logic [31:0] data_len;
		kind = $urandom_range(0, 99);
		if (kind < 6) begin
			// Plain noise.
			repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
		end else begin
			add_word(RIFF_TAG, 4);
			add_word($urandom, 4);
			add_word(WAVE_TAG, 4);
			if (kind < 14) begin
				// Break one byte of the fixed header text.
				pick = $urandom_range(0, 7);
				if (pick >= 4)
					pick = pick + 4;
				file_bytes[pick] = file_bytes[pick] ^ 8'($urandom_range(1, 255));
			end
			repeat ($urandom_range(0, 2)) add_junk_chunk();
			pick = $urandom_range(0, 9);
			n_fmt = (pick == 0) ? 0 : (pick < 8) ? 1 : 2;
			for (int i = 0; i < n_fmt; i++) begin
				// An earlier fmt chunk is often bad so that the override matters.
				add_fmt_chunk((i + 1 < n_fmt) ? ($urandom_range(0, 1) == 1)
				                              : ($urandom_range(0, 4) == 0));
				if ($urandom_range(0, 3) == 0)
					add_junk_chunk();
			end
			if ($urandom_range(0, 99) >= 8) begin
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					data_len = 0;
					n_data = 0;
				end else if (pick < 85) begin
					data_len = $urandom_range(1, 24);
					n_data = data_len;
				end else begin
					// Declared size far beyond what the file carries.
					data_len = $urandom;
					n_data = $urandom_range(0, 30);
				end
				add_word(TAG_DATA, 4);
				add_word(data_len, 4);
				repeat (n_data) file_bytes.push_back(8'($urandom));
				if ($urandom_range(0, 9) < 3)
					repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
			end
		end
		if ($urandom_range(0, 99) < 15)
			flush_file($urandom_range(0, file_bytes.size() - 1));
		else
			flush_file(file_bytes.size() - 1);
	endtask

	// Driver: bursts of random length with random gaps between them; half of the
	// gaps are empty, which gives long stretches with a byte on every cycle. An
	// offered byte stays put until the block takes it.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else begin
			if (byte_valid && byte_stall)
				input_stall_cycles++;
			if (byte_valid && !byte_stall) begin
				parse_wave_byte(byte_item);
				bytes_taken++;
			end
			if (!byte_valid || !byte_stall) begin
				if (gap_left != 0) begin
					byte_valid <= 1'b0;
					gap_left--;
				end else if (wave_stream.size() != 0) begin
					byte_valid <= 1'b1;
					byte_item <= wave_stream.pop_front();
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and receiver. The stall pattern switches at random between none,
	// random, periodic and heavy. Twice during the run the receiver holds off for
	// a long stretch so that the result queue fills and the block has to stall
	// its byte input.
	int stall_mode = 0;
	int mode_left = 0;
	int beat = 0;
	int hold_left = 0;
	int holds_done = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				check_result(result_item);
				results_seen++;
			end
			beat++;
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (holds_done < 2 && results_seen >= 40 + 120 * holds_done) begin
				hold_left = 60;
				holds_done++;
				result_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 1) == 1);
					2: result_stall <= (beat % 3 == 0);
					default: result_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	initial begin
		clear_parser();

		// A file cut off inside the header.
		file_bytes = '{8'h52, 8'h49};
		flush_file(1);
		// A bad second header byte of zero, then an ignored byte of all ones.
		file_bytes = '{8'h52, 8'h00, 8'hFF};
		flush_file(2);
		// A data chunk with no fmt chunk before it; the file ends on its header.
		add_word(RIFF_TAG, 4);
		add_word(32'hFFFF_FFFF, 4);
		add_word(WAVE_TAG, 4);
		add_word(TAG_DATA, 4);
		add_word(32'd16, 4);
		flush_file(file_bytes.size() - 1);

		while (wave_stream.size() < 775)
			build_wave_file();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every byte has been taken, then for the results to drain.
		@(posedge clk);
		while (wave_stream.size() != 0 || byte_valid)
			@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		// Give a stray extra result the chance to show up.
		repeat (20) @(posedge clk);
		if (awaited_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

		$display("covered %0d input bytes in %0d files: %0d ok, %0d bad header, %0d no usable PCM",
			bytes_taken, files_parsed, status_tally[ST_OK], status_tally[ST_HDR_BAD],
			status_tally[ST_NO_PCM]);
		$display("checked %0d results (%0d PCM bytes); input stalled on %0d cycles",
			results_seen, pcm_bytes_predicted, input_stall_cycles);
		if (mismatches == 0)
			$display("riff_wave_pcm_extractor_top: match");
		else
			$display("riff_wave_pcm_extractor_top: mismatch");
		$finish;
	end

	// Timeout: a correct run ends well inside this.
	initial begin
		#4_000_000;
		$display("riff_wave_pcm_extractor_top: mismatch");
		$finish;
	end

endmodule
